// ----- rtl/aarm_pkg.sv -----
// shared types, constants and the arctangent table of the axis-angle matrix block
`timescale 1ns / 1ps
package aarm_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;

	// cordic datapath width (x, y and z)
	localparam int CW = 34;

	localparam logic [24:0] DEG_QUARTER = 25'd5898240;
	localparam logic [24:0] DEG_HALF    = 25'd11796480;
	localparam logic [24:0] DEG_FULL    = 25'd23592960;
	localparam logic [24:0] DEG_TO_RAD  = 25'd18740330;
	localparam logic [CW-1:0] GAIN_Q30  = CW'(652032874);

	// offset that makes the integer degree part positive (92 * 360)
	localparam logic [16:0] DEG_OFFSET  = 17'd33120;
	// floor(2^25 / 360)
	localparam logic [16:0] RECIP_360   = 17'd93206;

	localparam logic signed [17:0] OUT_MAX = 18'sd131071;
	localparam logic signed [17:0] OUT_MIN = -18'sd131072;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} axis_t;

	typedef logic signed [17:0] entry_t;

	// atan(2^-i) in Q2.30
	function automatic logic signed [CW-1:0] atan_q30(input int i);
		logic [29:0] v;
		unique case (i)
			0: v = 30'd843314857;
			1: v = 30'd497837829;
			2: v = 30'd263043837;
			3: v = 30'd133525159;
			4: v = 30'd67021687;
			5: v = 30'd33543516;
			6: v = 30'd16775851;
			7: v = 30'd8388437;
			8: v = 30'd4194283;
			9: v = 30'd2097149;
			default: v = 30'd1 << (30 - i);
		endcase
		return $signed({{(CW-30){1'b0}}, v});
	endfunction

endpackage

// ----- rtl/axis_angle_rotation_matrix.sv -----
// top level: axis-angle to 3x3 rotation matrix pipeline
//
//  channel  | handshake          | fields
//  ---------+--------------------+------------------------------------------
//  input    | start, busy        | angle_deg, axis_x, axis_y, axis_z
//  result   | done (one cycle)   | m00 m01 m02 m10 m11 m12 m20 m21 m22
//
// one item per cycle; items pass angle reduction and conversion to radians,
// then the cordic iterations, then the matrix products.
// busy stays low: the pipeline never stalls and the receiver cannot stall.
// reset clears only the valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix import aarm_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] angle_deg,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               done,
	output logic signed [17:0] m00,
	output logic signed [17:0] m01,
	output logic signed [17:0] m02,
	output logic signed [17:0] m10,
	output logic signed [17:0] m11,
	output logic signed [17:0] m12,
	output logic signed [17:0] m20,
	output logic signed [17:0] m21,
	output logic signed [17:0] m22
);

	axis_t                in_axis, a_axis, c_axis;
	logic                 a_valid, c_valid;
	logic signed [CW-1:0] a_z, c_x, c_y;
	logic                 a_flip, c_flip;
	entry_t               m [9];

	assign busy    = 1'b0;
	assign in_axis = '{x: axis_x, y: axis_y, z: axis_z};

	aarm_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.angle_deg (angle_deg),
		.in_axis   (in_axis),
		.out_valid (a_valid),
		.out_z     (a_z),
		.out_flip  (a_flip),
		.out_axis  (a_axis)
	);

	aarm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_valid),
		.in_z      (a_z),
		.in_flip   (a_flip),
		.in_axis   (a_axis),
		.out_valid (c_valid),
		.out_x     (c_x),
		.out_y     (c_y),
		.out_flip  (c_flip),
		.out_axis  (c_axis)
	);

	aarm_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid),
		.in_x      (c_x),
		.in_y      (c_y),
		.in_flip   (c_flip),
		.in_axis   (c_axis),
		.out_valid (done),
		.out_m     (m)
	);

	assign m00 = m[0];
	assign m01 = m[1];
	assign m02 = m[2];
	assign m10 = m[3];
	assign m11 = m[4];
	assign m12 = m[5];
	assign m20 = m[6];
	assign m21 = m[7];
	assign m22 = m[8];

endmodule

// ----- rtl/aarm_angle.sv -----
// angle reduction modulo 360, folding and conversion to radians
`timescale 1ns / 1ps
module aarm_angle import aarm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [31:0]   angle_deg,
	input  axis_t                in_axis,
	output logic                 out_valid,
	output logic signed [CW-1:0] out_z,
	output logic                 out_flip,
	output axis_t                out_axis
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [16:0] h_s1;
	logic [15:0] frac_s1;
	logic [33:0] prod_s1;
	axis_t       ax_s1, ax_s2, ax_s3, ax_s4;
	logic [22:0] mag_s2;
	logic        neg_s2, flip_s2, neg_s3, flip_s3, flip_s4;
	logic [47:0] rad_s3;
	logic signed [CW-1:0] z_s4;

	logic [8:0]         q;
	logic [16:0]        r0;
	logic [8:0]         r;
	logic [24:0]        red;
	logic signed [25:0] fold;
	logic               flip;
	logic [47:0]        rnd;
	logic [31:0]        zmag;

	// integer part made positive, reciprocal of 360
	logic [16:0] h;
	assign h = 17'($signed(angle_deg[31:16]) + $signed({1'b0, DEG_OFFSET}));

	// remainder with one correction, then fold into [-90, 90]
	always_comb begin
		q  = prod_s1[33:25];
		r0 = h_s1 - 17'(q) * 17'd360;
		r  = (r0 >= 17'd360) ? 9'(r0 - 17'd360) : r0[8:0];
		red = {r, frac_s1};
		flip = 1'b0;
		if (red > DEG_QUARTER && red < 25'(3 * 5898240)) begin
			fold = $signed({1'b0, red}) - $signed({1'b0, DEG_HALF});
			flip = 1'b1;
		end else if (red >= 25'(3 * 5898240)) begin
			fold = $signed({1'b0, red}) - $signed({1'b0, DEG_FULL});
		end else begin
			fold = $signed({1'b0, red});
		end
	end

	// rounded radians magnitude
	always_comb begin
		rnd  = rad_s3 + 48'd32768;
		zmag = rnd[47:16];
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		h_s1    <= h;
		frac_s1 <= angle_deg[15:0];
		prod_s1 <= 34'(h) * 34'(RECIP_360);
		ax_s1   <= in_axis;

		mag_s2  <= fold[25] ? 23'(-fold) : 23'(fold);
		neg_s2  <= fold[25];
		flip_s2 <= flip;
		ax_s2   <= ax_s1;

		rad_s3  <= 48'(mag_s2) * 48'(DEG_TO_RAD);
		neg_s3  <= neg_s2;
		flip_s3 <= flip_s2;
		ax_s3   <= ax_s2;

		z_s4    <= neg_s3 ? -$signed({2'b00, zmag}) : $signed({2'b00, zmag});
		flip_s4 <= flip_s3;
		ax_s4   <= ax_s3;
	end

	assign out_valid = v_s4;
	assign out_z     = z_s4;
	assign out_flip  = flip_s4;
	assign out_axis  = ax_s4;

endmodule

// ----- rtl/aarm_cordic.sv -----
// rotation-mode cordic, one register stage per iteration
`timescale 1ns / 1ps
module aarm_cordic import aarm_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] in_z,
	input  logic                 in_flip,
	input  axis_t                in_axis,
	output logic                 out_valid,
	output logic signed [CW-1:0] out_x,
	output logic signed [CW-1:0] out_y,
	output logic                 out_flip,
	output axis_t                out_axis
);

	logic                 v_q    [CORDIC_STEPS+1];
	logic signed [CW-1:0] x_q    [CORDIC_STEPS+1];
	logic signed [CW-1:0] y_q    [CORDIC_STEPS+1];
	logic signed [CW-1:0] z_q    [CORDIC_STEPS+1];
	logic                 flip_q [CORDIC_STEPS+1];
	axis_t                ax_q   [CORDIC_STEPS+1];

	assign v_q[0]    = in_valid;
	assign x_q[0]    = GAIN_Q30;
	assign y_q[0]    = '0;
	assign z_q[0]    = in_z;
	assign flip_q[0] = in_flip;
	assign ax_q[0]   = in_axis;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CW-1:0] dx, dy, at;
		assign dx = x_q[i] >>> i;
		assign dy = y_q[i] >>> i;
		assign at = atan_q30(i);

		// valid bit of this iteration
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else begin
				v_q[i+1] <= v_q[i];
			end
		end

		// micro-rotation by the sign of the residual angle
		always_ff @(posedge clk) begin
			if (!z_q[i][CW-1]) begin
				x_q[i+1] <= x_q[i] - dy;
				y_q[i+1] <= y_q[i] + dx;
				z_q[i+1] <= z_q[i] - at;
			end else begin
				x_q[i+1] <= x_q[i] + dy;
				y_q[i+1] <= y_q[i] - dx;
				z_q[i+1] <= z_q[i] + at;
			end
			flip_q[i+1] <= flip_q[i];
			ax_q[i+1]   <= ax_q[i];
		end
	end

	assign out_valid = v_q[CORDIC_STEPS];
	assign out_x     = x_q[CORDIC_STEPS];
	assign out_y     = y_q[CORDIC_STEPS];
	assign out_flip  = flip_q[CORDIC_STEPS];
	assign out_axis  = ax_q[CORDIC_STEPS];

endmodule

// ----- rtl/aarm_matrix.sv -----
// rodrigues matrix products, rounding and saturation
`timescale 1ns / 1ps
module aarm_matrix import aarm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] in_x,
	input  logic signed [CW-1:0] in_y,
	input  logic                 in_flip,
	input  axis_t                in_axis,
	output logic                 out_valid,
	output entry_t               out_m [9]
);

	logic              v_s1, v_s2, v_s3;
	logic signed [CW-1:0] c_s1, s_s1;
	logic signed [CW:0]   omc_s1;
	logic signed [31:0]   p_s1 [6];
	axis_t                ax_s1;
	logic signed [67:0]   t_s2 [6];
	logic signed [67:0]   sa_s2 [3];
	logic signed [67:0]   cq_s2;
	entry_t               m_s3 [9];

	logic signed [CW-1:0] c, s;
	logic signed [67:0]   e [9];

	assign c = in_flip ? -in_x : in_x;
	assign s = in_flip ? -in_y : in_y;

	// entry sums before rounding
	assign e[0] = t_s2[0] + cq_s2;
	assign e[1] = t_s2[3] - sa_s2[2];
	assign e[2] = t_s2[4] + sa_s2[1];
	assign e[3] = t_s2[3] + sa_s2[2];
	assign e[4] = t_s2[1] + cq_s2;
	assign e[5] = t_s2[5] - sa_s2[0];
	assign e[6] = t_s2[4] - sa_s2[1];
	assign e[7] = t_s2[5] + sa_s2[0];
	assign e[8] = t_s2[2] + cq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// axis pair products and one minus cosine
	always_ff @(posedge clk) begin
		c_s1   <= c;
		s_s1   <= s;
		omc_s1 <= $signed((CW+1)'(1) <<< 30) - (CW+1)'(c);
		p_s1[0] <= in_axis.x * in_axis.x;
		p_s1[1] <= in_axis.y * in_axis.y;
		p_s1[2] <= in_axis.z * in_axis.z;
		p_s1[3] <= in_axis.x * in_axis.y;
		p_s1[4] <= in_axis.x * in_axis.z;
		p_s1[5] <= in_axis.y * in_axis.z;
		ax_s1   <= in_axis;
	end

	// scaled products in q58
	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			t_s2[k] <= 68'(omc_s1) * 68'(p_s1[k]);
		end
		sa_s2[0] <= (68'(s_s1) * 68'(ax_s1.x)) <<< 14;
		sa_s2[1] <= (68'(s_s1) * 68'(ax_s1.y)) <<< 14;
		sa_s2[2] <= (68'(s_s1) * 68'(ax_s1.z)) <<< 14;
		cq_s2    <= 68'(c_s1) <<< 28;
	end

	// round half up to q2.16 and saturate
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			logic signed [67:0] rs;
			rs = (e[k] + (68'sd1 <<< 41)) >>> 42;
			if (rs > 68'(OUT_MAX)) begin
				m_s3[k] <= OUT_MAX;
			end else if (rs < 68'(OUT_MIN)) begin
				m_s3[k] <= OUT_MIN;
			end else begin
				m_s3[k] <= rs[17:0];
			end
		end
	end

	assign out_valid = v_s3;
	assign out_m     = m_s3;

endmodule

// ----- sim/axis_angle_rotation_matrix_tb.sv -----
// testbench for the axis-angle rotation matrix block: random and directed items against a predictor
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_tb;
	import aarm_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam int LATENCY = STEPS + 7;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic signed [17:0] e [9];
	} matrix_t;

	// rodrigues matrix predictor and store of expected matrices
	class matrix_scoreboard;
		matrix_t pending [$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function automatic longint shr_floor(longint v, int s);
			return v >>> s;
		endfunction

		function automatic logic signed [17:0] round_sat(longint q58);
			longint r;
			r = (q58 + (64'sd1 <<< 41)) >>> 42;
			if (r > 131071) r = 131071;
			if (r < -131072) r = -131072;
			return r[17:0];
		endfunction

		function automatic matrix_t rotation(logic signed [31:0] deg, logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] az);
			longint red, mag, z, x, y, dx, dy, c, s, omc, cq, sx, sy, sz, at;
			longint a0, a1, a2;
			bit flip;
			matrix_t m;
			flip = 0;
			red = longint'(deg) % 23592960;
			if (red < 0) red += 23592960;
			if (red > 5898240 && red < 3 * 5898240) begin
				red -= 11796480;
				flip = 1;
			end else if (red >= 3 * 5898240) begin
				red -= 23592960;
			end
			mag = red < 0 ? -red : red;
			z = (mag * 18740330 + 32768) >>> 16;
			if (red < 0) z = -z;
			x = 652032874;
			y = 0;
			for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
				at = atan_q30(i);
				dx = shr_floor(y, i);
				dy = shr_floor(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= at;
				end else begin
					x += dx; y -= dy; z += at;
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
			a0 = ax; a1 = ay; a2 = az;
			omc = (64'sd1 <<< 30) - c;
			cq = c * (64'sd1 <<< 28);
			sx = s * a0 * 16384;
			sy = s * a1 * 16384;
			sz = s * a2 * 16384;
			m.e[0] = round_sat(omc * a0 * a0 + cq);
			m.e[1] = round_sat(omc * a0 * a1 - sz);
			m.e[2] = round_sat(omc * a0 * a2 + sy);
			m.e[3] = round_sat(omc * a0 * a1 + sz);
			m.e[4] = round_sat(omc * a1 * a1 + cq);
			m.e[5] = round_sat(omc * a1 * a2 - sx);
			m.e[6] = round_sat(omc * a0 * a2 - sy);
			m.e[7] = round_sat(omc * a1 * a2 + sx);
			m.e[8] = round_sat(omc * a2 * a2 + cq);
			return m;
		endfunction

		function void note_item(logic signed [31:0] deg, logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] az);
			pending.push_back(rotation(deg, ax, ay, az));
		endfunction

		function void check_matrix(matrix_t got);
			matrix_t want;
			if (pending.size() == 0) begin
				$display("%0t: matrix with none expected", $realtime);
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int k = 0; k < 9; k++)
				if (got.e[k] !== want.e[k]) begin
					$display("%0t: m%0d%0d expected %0d actual %0d", $realtime, k / 3, k % 3,
						want.e[k], got.e[k]);
					errors++;
				end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	logic signed [31:0] angle_deg;
	logic signed [15:0] axis_x, axis_y, axis_z;
	logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	matrix_scoreboard sb;
	int idle_cycles;

	axis_angle_rotation_matrix dut (.*);

	// clock
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// result capture
	always @(posedge clk) begin
		matrix_t got;
		if (arst_n && done) begin
			got.e = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			sb.check_matrix(got);
		end
	end

	// watchdog on cycles with nothing accepted and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one item and hold it until taken
	task automatic send_item(logic signed [31:0] deg, logic signed [15:0] ax,
		logic signed [15:0] ay, logic signed [15:0] az);
		start <= 1;
		angle_deg <= deg;
		axis_x <= ax;
		axis_y <= ay;
		axis_z <= az;
		do @(posedge clk); while (busy);
		sb.note_item(deg, ax, ay, az);
	endtask

	task automatic pause(int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_axis_part();
		// mostly unit-ish values, sometimes the full range
		if ($urandom_range(0, 3) == 0) return 16'($urandom());
		return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
	endfunction

	function automatic logic signed [31:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'(int'($urandom_range(0, 720)) - 360) <<< 16;
			2: return $signed(32'($urandom_range(0, 2 * 23592960))) - 32'sd23592960;
			default: return (32'(int'($urandom_range(0, 8)) - 4) * 32'sd5898240)
				+ 32'($urandom_range(0, 2)) - 32'sd1;
		endcase
	endfunction

	initial begin
		int burst;
		sb = new();
		start = 0;
		angle_deg = 0;
		axis_x = 0;
		axis_y = 0;
		axis_z = 0;
		idle_cycles = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: axes, quadrant edges, extreme angles and axis values
		send_item(0, 16384, 0, 0);
		send_item(32'sd90 <<< 16, 0, 0, 16384);
		send_item(32'sd5898241, 0, 16384, 0);
		send_item(32'sd180 <<< 16, 16384, 0, 0);
		send_item(32'sd270 <<< 16, 0, 16384, 0);
		send_item(32'sd17694720, 0, 0, 16384);
		send_item(32'sd360 <<< 16, 9459, 9459, 9459);
		send_item(-(32'sd90 <<< 16), 0, 0, -16384);
		send_item(-(32'sd45 <<< 16), 11585, -11585, 0);
		send_item(32'h7fffffff, 16384, 0, 0);
		send_item(32'h80000000, 0, 16384, 0);
		send_item(32'hffffffff, 0, 0, 16384);
		send_item(32'sd30 <<< 16, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_item(32'sd120 <<< 16, 16'sh8000, 16'sh8000, 16'sh8000);
		send_item(32'sd200 <<< 16, 16'sh7fff, 16'sh8000, 0);
		send_item(32'sd1, 16'shffff, 16'sh0001, 16'sh5555);
		send_item(32'h55555555, 16'shaaaa, 16'sh5555, 16'shffff);
		send_item(32'haaaaaaaa, 0, 0, 0);

		// drain before the random part
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);

		// random bursts with random gaps
		for (int n = 0; n < 650; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < 650; b++, n++)
				send_item(rand_angle(), rand_axis_part(), rand_axis_part(), rand_axis_part());
			case ($urandom_range(0, 3))
				0: ;
				1: pause($urandom_range(1, 3));
				2: pause($urandom_range(1, LATENCY + 5));
				default: begin
					start <= 0;
					while (sb.pending.size() != 0) @(posedge clk);
				end
			endcase
		end

		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/aarm_pkg.sv
rtl/aarm_angle.sv
rtl/aarm_cordic.sv
rtl/aarm_matrix.sv
rtl/axis_angle_rotation_matrix.sv
sim/axis_angle_rotation_matrix_tb.sv
